@@ sv/pic_pkg.sv @@
// pic_pkg: shared types, constants and helpers for the interrupt controller
// no dependencies
`default_nettype none
package pic_pkg;
   localparam int NUM_SOURCES_DEF  = 64;
   localparam int NUM_TARGETS_DEF  = 2;
   localparam int ENABLE_WORDS_DEF = 2;

   localparam int ADDR_W = 26;
   localparam int DATA_W = 64;
   localparam int SRC_W  = 6;

   localparam logic [ADDR_W-1:0] PEND_BASE   = 26'h0001000;
   localparam logic [ADDR_W-1:0] ENABLE_BASE = 26'h0002000;
   localparam logic [ADDR_W-1:0] THRESH_BASE = 26'h0200000;

   typedef enum logic [1:0] {
      ACT_READ  = 2'd0,
      ACT_WRITE = 2'd1,
      ACT_LEVEL = 2'd2,
      ACT_TICK  = 2'd3
   } action_type;

   typedef enum logic [2:0] {
      SZ_DWORD = 3'd0, SZ_WORD = 3'd1, SZ_WORDU = 3'd2, SZ_HALF = 3'd3,
      SZ_HALFU = 3'd4, SZ_BYTE = 3'd5, SZ_BYTEU = 3'd6, SZ_RSVD = 3'd7
   } size_type;

   typedef enum logic [2:0] {
      ST_IDLE, ST_EXEC, ST_SCAN, ST_DECIDE, ST_RESP
   } state_type;

   // commands from controller to datapath
   typedef struct packed {
      logic load;       // capture a new beat
      logic exec;       // perform read/write/level update
      logic scan_start; // start scan at the first target
      logic scan_step;  // look at one source
      logic decide;     // finish current target
      logic next_tgt;   // advance target
   } cmd_type;

   // status from datapath to controller
   typedef struct packed {
      logic is_tick;
      logic scan_last;
      logic tgt_last;
   } sts_type;

   // mask data to access size
   function automatic logic [DATA_W-1:0] size_mask(input logic [2:0] sz);
      logic [DATA_W-1:0] m;
      m = '1;
      case (sz)
         SZ_WORD, SZ_WORDU: m = 64'h0000_0000_ffff_ffff;
         SZ_HALF, SZ_HALFU: m = 64'h0000_0000_0000_ffff;
         SZ_BYTE, SZ_BYTEU: m = 64'h0000_0000_0000_00ff;
         default:           m = '1;
      endcase
      return m;
   endfunction

   // sign or zero extension of read data
   function automatic logic [DATA_W-1:0] extend(input logic [DATA_W-1:0] v,
                                                input logic [2:0] sz);
      logic [DATA_W-1:0] r;
      r = v;
      case (sz)
         SZ_WORD:  r = {{32{v[31]}}, v[31:0]};
         SZ_WORDU: r = {32'd0, v[31:0]};
         SZ_HALF:  r = {{48{v[15]}}, v[15:0]};
         SZ_HALFU: r = {48'd0, v[15:0]};
         SZ_BYTE:  r = {{56{v[7]}}, v[7:0]};
         SZ_BYTEU: r = {56'd0, v[7:0]};
         default:  r = v;
      endcase
      return r;
   endfunction
endpackage
`default_nettype wire

@@ sv/platform_interrupt_controller_top.sv @@
// platform_interrupt_controller_top: stream wrapper around controller and datapath
// depends on pic_pkg, pic_ctrl, pic_datapath
//
//  channel | dir | payload
//  req     | in  | tdata: action, bus_addr, access_size, write_value, source_number, source_level
//  rsp     | out | tdata: read_value, irq_lines
//  csr     | in  | target_connected
//
// reads, writes and level updates pass from the beat through the exec state to the response.
// a tick runs the one-source-per-cycle scan of the priority memory read port over
// min(NUM_SOURCES,32*ENABLE_WORDS) sources for each of the NUM_TARGETS targets.
// reset is synchronous, sparing the captured beat and priority memory; priorities read as zero after reset.
// a stalled response holds; the next beat is taken in the cycle the response leaves.
`default_nettype none
module platform_interrupt_controller_top
   import pic_pkg::*;
#(
   parameter int NUM_SOURCES  = NUM_SOURCES_DEF,
   parameter int NUM_TARGETS  = NUM_TARGETS_DEF,
   parameter int ENABLE_WORDS = ENABLE_WORDS_DEF
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   // action[1:0], bus_addr[27:2], access_size[30:28], write_value[94:31],
   // source_number[100:95], source_level[101], zero fill to 104
   input  wire logic [103:0]           req_tdata,
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   // read_value[63:0], irq_lines from bit 64, zero fill
   output logic [((DATA_W+NUM_TARGETS+7)/8)*8-1:0] rsp_tdata,
   input  wire logic                   csr_wen,
   input  wire logic [NUM_TARGETS-1:0] csr_wdata
);
   localparam int RW = ((DATA_W + NUM_TARGETS + 7) / 8) * 8;

   cmd_type cmd;
   sts_type sts;
   logic [NUM_TARGETS-1:0] conn_ff;
   logic [DATA_W-1:0]      rv;
   logic [NUM_TARGETS-1:0] lines;

   // target connection register
   always_ff @(posedge clock) begin
      if (reset) conn_ff <= '0;
      else if (csr_wen) conn_ff <= csr_wdata;
   end

   pic_ctrl u_ctrl (
      .clock, .reset, .req_tvalid, .req_tready, .rsp_tvalid, .rsp_tready,
      .cmd, .sts
   );

   pic_datapath #(
      .NUM_SOURCES(NUM_SOURCES), .NUM_TARGETS(NUM_TARGETS),
      .ENABLE_WORDS(ENABLE_WORDS)
   ) u_dp (
      .clock, .reset, .cmd, .sts, .connected(conn_ff),
      .in_action(req_tdata[1:0]), .in_addr(req_tdata[27:2]),
      .in_size(req_tdata[30:28]), .in_wdata(req_tdata[94:31]),
      .in_src(req_tdata[100:95]), .in_level(req_tdata[101]),
      .read_value(rv), .irq_lines(lines)
   );

   assign rsp_tdata = RW'({lines, rv});
endmodule
`default_nettype wire

@@ sv/pic_ctrl.sv @@
// pic_ctrl: sequencing state machine of the interrupt controller
// depends on pic_pkg
`default_nettype none
module pic_ctrl
   import pic_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_tvalid,
   output logic         req_tready,
   output logic         rsp_tvalid,
   input  wire logic    rsp_tready,
   output cmd_type      cmd,
   input  wire sts_type sts
);
   state_type state_ff, state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else       state_ff <= state_in;
   end

   // next state and commands
   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      rsp_tvalid = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (sts.is_tick) begin
               cmd.scan_start = 1'b1;
               state_in       = ST_SCAN;
            end else begin
               cmd.exec = 1'b1;
               state_in = ST_RESP;
            end
         end
         ST_SCAN: begin
            cmd.scan_step = 1'b1;
            if (sts.scan_last) state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            cmd.decide = 1'b1;
            if (sts.tgt_last) state_in = ST_RESP;
            else begin
               cmd.next_tgt = 1'b1;
               state_in     = ST_SCAN;
            end
         end
         ST_RESP: begin
            rsp_tvalid = 1'b1;
            if (rsp_tready) begin
               req_tready = 1'b1;
               if (req_tvalid) begin
                  cmd.load = 1'b1;
                  state_in = ST_EXEC;
               end else state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // a response is only shown from the response state
   a_rsp_state: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> state_ff == ST_RESP) else $error("rsp outside resp state");
   // a scan always ends in a decision
   a_scan_dec: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN && sts.scan_last) |=> state_ff == ST_DECIDE)
      else $error("scan did not decide");
   // never take a beat while working
   a_no_take: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN || state_ff == ST_DECIDE || state_ff == ST_EXEC)
      |-> !req_tready) else $error("ready while busy");
endmodule
`default_nettype wire

@@ sv/pic_datapath.sv @@
// pic_datapath: register file, bus decode and sequential arbitration scan
// depends on pic_pkg
`default_nettype none
module pic_datapath
   import pic_pkg::*;
#(
   parameter int NUM_SOURCES  = NUM_SOURCES_DEF,
   parameter int NUM_TARGETS  = NUM_TARGETS_DEF,
   parameter int ENABLE_WORDS = ENABLE_WORDS_DEF
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire cmd_type                cmd,
   output sts_type                     sts,
   input  wire logic [NUM_TARGETS-1:0] connected,
   input  wire logic [1:0]             in_action,
   input  wire logic [ADDR_W-1:0]      in_addr,
   input  wire logic [2:0]             in_size,
   input  wire logic [DATA_W-1:0]      in_wdata,
   input  wire logic [SRC_W-1:0]       in_src,
   input  wire logic                   in_level,
   output logic [DATA_W-1:0]           read_value,
   output logic [NUM_TARGETS-1:0]      irq_lines
);
   localparam int SW   = $clog2(NUM_SOURCES);
   localparam int TW   = (NUM_TARGETS > 1) ? $clog2(NUM_TARGETS) : 1;
   localparam int WW   = (ENABLE_WORDS > 1) ? $clog2(ENABLE_WORDS) : 1;
   localparam int NBIT = ENABLE_WORDS * 32;
   localparam int IDW  = $clog2(NBIT);
   // scan covers whichever is smaller: mapped sources or enable bits
   localparam int SCAN_N = (NUM_SOURCES < NBIT) ? NUM_SOURCES : NBIT;
   localparam int CW     = $clog2(SCAN_N);
   localparam int NE     = NUM_TARGETS * ENABLE_WORDS;
   localparam int EW     = $clog2(NE) + 1;

   // captured beat
   logic [1:0]        act_ff;
   logic [ADDR_W-1:0] addr_ff;
   logic [2:0]        size_ff;
   logic [DATA_W-1:0] wdata_ff;
   logic [SRC_W-1:0]  src_ff;
   logic              lvl_ff;

   // state
   logic [31:0]         prio_mem [NUM_SOURCES];
   logic [NUM_SOURCES-1:0] prio_vld_ff;
   logic [NBIT-1:0]     pend_ff, disp_ff;
   logic [31:0]         en_ff [NE];
   logic [31:0]         thr_ff [NUM_TARGETS];
   logic [SRC_W-1:0]    claim_ff [NUM_TARGETS];
   logic [NUM_TARGETS-1:0] line_ff;
   logic [DATA_W-1:0]   rdata_ff;

   // scan state
   logic [CW-1:0]  idx_ff;
   logic [TW-1:0]  tgt_ff;
   logic [SW-1:0]  best_ff;
   logic [31:0]    bprio_ff;
   logic           bvalid_ff;
   logic [31:0]    prio_rd_ff;
   logic           scan_vld_ff;
   logic [31:0]    prio_scan;
   logic [31:0]    prio_bus_ff;
   logic           bus_vld_ff;
   logic [CW-1:0]  pidx_ff;
   logic           pval_ff;

   // bus address decode
   logic        a_thr, a_en, a_pend;
   logic [ADDR_W-1:0] off_thr, off_en, off_pend;
   logic [ADDR_W-12-1:0] t_thr;
   logic [ADDR_W-7-1:0]  t_en;
   logic [4:0]  n_en;
   logic [ADDR_W-2-1:0] n_pend, n_prio;
   logic        thr_ok, en_ok, pend_ok, prio_ok;
   logic [TW-1:0] ti_thr, ti_en;
   logic [EW-1:0] e_idx;
   logic [31:0]   wv;
   logic [31:0]   rd32;
   logic [SRC_W-1:0] cid;
   logic [IDW-1:0]   cbit;

   function automatic logic [DATA_W-1:0] in_wdata_masked(input logic [DATA_W-1:0] d,
                                                         input logic [2:0] sz);
      return d & size_mask(sz);
   endfunction

   always_comb begin
      a_thr    = addr_ff >= THRESH_BASE;
      a_en     = !a_thr && addr_ff >= ENABLE_BASE;
      a_pend   = !a_thr && !a_en && addr_ff >= PEND_BASE;
      off_thr  = addr_ff - THRESH_BASE;
      off_en   = addr_ff - ENABLE_BASE;
      off_pend = addr_ff - PEND_BASE;
      t_thr    = off_thr[ADDR_W-1:12];
      t_en     = off_en[ADDR_W-1:7];
      n_en     = addr_ff[6:2];
      n_pend   = off_pend[ADDR_W-1:2];
      n_prio   = addr_ff[ADDR_W-1:2];
      thr_ok   = a_thr && (t_thr < (ADDR_W-12)'(NUM_TARGETS));
      en_ok    = a_en && (t_en < (ADDR_W-7)'(NUM_TARGETS)) && (n_en < 5'(ENABLE_WORDS));
      pend_ok  = a_pend && (n_pend < (ADDR_W-2)'(ENABLE_WORDS));
      prio_ok  = !a_thr && !a_en && !a_pend && (n_prio < (ADDR_W-2)'(NUM_SOURCES));
      ti_thr   = TW'(t_thr);
      ti_en    = TW'(t_en);
      e_idx    = EW'(ti_en) * EW'(ENABLE_WORDS) + EW'(n_en);
      wv       = 32'(in_wdata_masked(wdata_ff, size_ff));
      cid      = claim_ff[ti_thr];
      // claimed id bit position, word index taken modulo the word count
      cbit     = IDW'({WW'((cid >> 5) % ENABLE_WORDS), cid[4:0]});
      rd32     = '0;
      if (thr_ok) rd32 = addr_ff[2] ? 32'(cid) : thr_ff[ti_thr];
      else if (en_ok) rd32 = en_ff[e_idx[EW-2:0]];
      else if (pend_ok) rd32 = pend_ff[32*WW'(n_pend) +: 32];
      else if (prio_ok) rd32 = bus_vld_ff ? prio_bus_ff : '0;
   end

   // scan: candidate bit of the current source
   logic [IDW-1:0] sid;
   logic           cand;
   logic [WW-1:0]  sw;
   logic [EW-1:0]  se;
   always_comb begin
      sid  = IDW'(idx_ff);
      sw   = WW'(sid >> 5);
      se   = EW'(tgt_ff) * EW'(ENABLE_WORDS) + EW'(sw);
      cand = en_ff[se[EW-2:0]][sid[4:0]] & pend_ff[sid] & ~disp_ff[sid];
   end

   // unwritten priorities read as zero
   assign prio_scan = scan_vld_ff ? prio_rd_ff : '0;

   assign sts.is_tick   = act_ff == ACT_TICK;
   assign sts.scan_last = !pval_ff ? 1'b0 : (pidx_ff == CW'(SCAN_N - 1));
   assign sts.tgt_last  = tgt_ff == TW'(NUM_TARGETS - 1);

   // capture beat
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         act_ff   <= in_action;
         addr_ff  <= in_addr;
         size_ff  <= in_size;
         wdata_ff <= in_wdata;
         src_ff   <= in_src;
         lvl_ff   <= in_level;
      end
   end

   // priority memory: one write port, registered reads for the bus and the scan
   always_ff @(posedge clock) begin
      if (cmd.exec && act_ff == ACT_WRITE && prio_ok && n_prio != '0)
         prio_mem[SW'(n_prio)] <= wv;
      prio_rd_ff <= prio_mem[SW'(idx_ff)];
      if (cmd.load) prio_bus_ff <= prio_mem[SW'(in_addr[ADDR_W-1:2])];
   end

   // written marks of the priority memory
   always_ff @(posedge clock) begin
      if (reset) begin
         prio_vld_ff <= '0;
         scan_vld_ff <= 1'b0;
         bus_vld_ff  <= 1'b0;
      end else begin
         if (cmd.exec && act_ff == ACT_WRITE && prio_ok && n_prio != '0)
            prio_vld_ff[SW'(n_prio)] <= 1'b1;
         scan_vld_ff <= prio_vld_ff[SW'(idx_ff)];
         if (cmd.load) bus_vld_ff <= prio_vld_ff[SW'(in_addr[ADDR_W-1:2])];
      end
   end

   // scan index, and pidx_ff for the source whose registered priority read is now returned
   always_ff @(posedge clock) begin
      if (reset) begin
         pval_ff <= 1'b0;
         idx_ff  <= '0;
         pidx_ff <= '0;
      end else begin
         if (cmd.scan_start || cmd.next_tgt) begin
            idx_ff  <= '0;
            pval_ff <= 1'b0;
         end else if (cmd.scan_step) begin
            pidx_ff <= idx_ff;
            pval_ff <= 1'b1;
            if (idx_ff != CW'(SCAN_N - 1)) idx_ff <= idx_ff + 1'b1;
         end
      end
   end

   // candidate pipelined alongside the read
   logic cand_ff;
   always_ff @(posedge clock) begin
      if (cmd.scan_step) cand_ff <= cand;
   end

   // control registers and arbitration
   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff   <= '0;
         disp_ff   <= '0;
         line_ff   <= '0;
         tgt_ff    <= '0;
         bvalid_ff <= 1'b0;
         best_ff   <= '0;
         bprio_ff  <= '0;
         rdata_ff  <= '0;
         for (int i = 0; i < NE; i++) en_ff[i] <= '0;
         for (int i = 0; i < NUM_TARGETS; i++) begin
            thr_ff[i]   <= '0;
            claim_ff[i] <= '0;
         end
      end else begin
         if (cmd.load) rdata_ff <= '0;
         if (cmd.scan_start) tgt_ff <= '0;
         if (cmd.next_tgt) tgt_ff <= tgt_ff + 1'b1;
         if (cmd.scan_start || cmd.next_tgt) begin
            bvalid_ff <= 1'b0;
            best_ff   <= '0;
            bprio_ff  <= '0;
         end
         // compare the source read last cycle against the best so far
         if (cmd.scan_step && pval_ff && cand_ff && prio_scan > bprio_ff
             && pidx_ff != '0) begin
            best_ff   <= SW'(pidx_ff);
            bprio_ff  <= prio_scan;
            bvalid_ff <= 1'b1;
         end
         if (cmd.decide) begin
            if (connected[tgt_ff] && !line_ff[tgt_ff] && bvalid_ff
                && bprio_ff > thr_ff[tgt_ff]) begin
               line_ff[tgt_ff]  <= 1'b1;
               claim_ff[tgt_ff] <= SRC_W'(best_ff);
               disp_ff[IDW'(best_ff)] <= 1'b1;
            end
         end
         if (cmd.exec) begin
            unique case (act_ff)
               ACT_READ: begin
                  rdata_ff <= extend({32'd0, rd32}, size_ff);
                  if (thr_ok && addr_ff[2]) begin
                     pend_ff[cbit] <= 1'b0;
                     disp_ff[cbit] <= 1'b0;
                  end
               end
               ACT_WRITE: begin
                  if (thr_ok) begin
                     if (addr_ff[2]) begin
                        claim_ff[ti_thr] <= '0;
                        line_ff[ti_thr]  <= 1'b0;
                     end else thr_ff[ti_thr] <= wv;
                  end else if (en_ok) en_ff[e_idx[EW-2:0]] <= wv;
               end
               ACT_LEVEL: begin
                  if ((src_ff >> 5) < SRC_W'(ENABLE_WORDS))
                     pend_ff[IDW'(src_ff)] <= lvl_ff;
               end
               default: ;
            endcase
         end
      end
   end

   assign read_value = rdata_ff;
   assign irq_lines  = line_ff;

   // a raised line always holds a non-zero claimed id
   a_claim_nz: assert property (@(posedge clock) disable iff (reset)
      (cmd.decide && $past(cmd.scan_step)) |=> (!$rose(line_ff[$past(tgt_ff)])
      || claim_ff[$past(tgt_ff)] != '0)) else $error("line raised with id 0");
   // the best source never has priority zero
   a_best_prio: assert property (@(posedge clock) disable iff (reset)
      bvalid_ff |-> bprio_ff != '0) else $error("best with zero priority");
   // lines only rise during a decision
   a_line_rise: assert property (@(posedge clock) disable iff (reset)
      (line_ff & ~$past(line_ff)) != '0 |-> $past(cmd.decide))
      else $error("line rose outside decision");
endmodule
`default_nettype wire
